[rtl/core/sle_pkg.sv]
// Shared types, codes and the match test for the sequential list engine.
package sle_pkg;

	// Command codes taken on the input channel.
	typedef enum logic [2:0] {
		CMD_INSERT = 3'd0,
		CMD_DELETE = 3'd1,
		CMD_LOCATE = 3'd2,
		CMD_NEXT   = 3'd3,
		CMD_PRIOR  = 3'd4
	} sle_cmd_t;

	// Status codes returned with every result.
	typedef enum logic [2:0] {
		STS_OK        = 3'd0,
		STS_BAD_INS   = 3'd1,
		STS_BAD_DEL   = 3'd2,
		STS_FULL      = 3'd3,
		STS_NOT_FOUND = 3'd4,
		STS_NO_NEXT   = 3'd5,
		STS_NO_PRIOR  = 3'd6
	} sle_status_t;

	// Locate tests.
	typedef enum logic [1:0] {
		MODE_EQUAL    = 2'd0,
		MODE_KEY_SQ   = 2'd1,
		MODE_ENTRY_SQ = 2'd2
	} sle_mode_t;

	// Sequencer states, one-hot.
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_UP     = 6'b000010,
		ST_DN     = 6'b000100,
		ST_SCAN   = 6'b001000,
		ST_NBR    = 6'b010000,
		ST_FINISH = 6'b100000
	} sle_state_t;

	// Tests one stored entry against the key. The key square is computed once per
	// command; sq_fits says it is below 2^31 and sq_low holds its low 31 bits.
	// An entry whose square fits in 31 bits is below 2^16, so a 16-bit square does.
	function automatic logic sle_match(
		input logic [31:0] entry,
		input logic [31:0] key,
		input logic        sq_fits,
		input logic [30:0] sq_low,
		input logic [1:0]  mode
	);
		logic [31:0] esq;
		logic        hit;
		esq = {16'd0, entry[15:0]} * {16'd0, entry[15:0]};
		case (mode)
			MODE_EQUAL:    hit = (entry == key);
			MODE_KEY_SQ:   hit = !entry[31] && sq_fits && (entry[30:0] == sq_low);
			MODE_ENTRY_SQ: hit = (entry[31:16] == 16'd0) && !key[31] && (esq == key);
			default:       hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage

[rtl/core/sequential_list_engine.sv]
// Bad positions, a full store, unknown commands and an empty locate go straight to the
// finish step. Insert shifts entries from the tail down to the position, delete shifts
// the entries after the position up, locate scans from the head to the first hit or the
// end, and next and prior read one neighbour. Commands are taken one at a time: the input
// stalls until the result enters the output register. The single read port moves one entry a cycle.
// Reset clears the entry count and control state; memory contents stay undefined.
module sequential_list_engine #(
	parameter int CAPACITY = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         command,
	input  logic [4:0]         position,
	input  logic signed [31:0] value,
	input  logic [1:0]         match_mode,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [3:0]         found_index,
	output logic signed [31:0] element,
	output logic [4:0]         list_length
);
	import sle_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = ((CW > 5) ? CW : 5) + 1;

	// Entry memory and its registered read port.
	logic [31:0]   mem [CAPACITY];
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [31:0]   rd_data_s1;
	logic [AW-1:0] rd_addr_s1;
	logic          rd_vld_s1;

	// Sequencer state.
	sle_state_t    state_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] ptr_q;
	logic [PW-1:0] lim_q;
	logic          issue_q;
	logic [PW-1:0] pos_q;
	logic [31:0]   val_q;
	logic [1:0]    mode_q;
	logic          sq_fits_q;
	logic [30:0]   sq_low_q;
	sle_status_t   res_status_q;
	logic [3:0]    res_found_q;
	logic [31:0]   res_elem_q;

	// Output register.
	logic          out_valid_q;
	logic [2:0]    status_q;
	logic [3:0]    found_q;
	logic [31:0]   elem_q;
	logic [4:0]    len_q;

	logic [PW-1:0] pos_x;
	logic [PW-1:0] cnt_x;
	logic [31:0]   key_abs;
	logic [63:0]   key_sq;
	logic          hit;
	logic          out_free;
	logic          scan_hit;

	assign pos_x    = PW'(position);
	assign cnt_x    = PW'(cnt_q);
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Key square for the locate test, taken when the command is accepted.
	assign key_abs = value[31] ? (32'd0 - value) : value;
	assign key_sq  = key_abs * key_abs;

	assign hit      = sle_match(rd_data_s1, val_q, sq_fits_q, sq_low_q, mode_q);
	assign scan_hit = (state_q == ST_SCAN) && rd_vld_s1 && hit;

	// One read per cycle while the current walk still has entries to fetch.
	assign mem_re    = issue_q;
	assign mem_raddr = ptr_q[AW-1:0];

	// Shifts write back the entry held by the registered read port; insert ends with the new value.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rd_addr_s1;
		mem_wdata = rd_data_s1;
		if (state_q == ST_UP) begin
			if (rd_vld_s1) begin
				mem_we    = 1'b1;
				mem_waddr = rd_addr_s1 + AW'(1);
			end else if (!issue_q) begin
				mem_we    = 1'b1;
				mem_waddr = pos_q[AW-1:0];
				mem_wdata = val_q;
			end
		end else if (state_q == ST_DN && rd_vld_s1) begin
			mem_we    = 1'b1;
			mem_waddr = rd_addr_s1 - AW'(1);
		end
	end

	// Memory array with a registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_s1 <= mem[mem_raddr];
		end
		rd_addr_s1 <= mem_raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= mem_re;
		end
	end

	// Payload registers of the command in progress.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			pos_q     <= pos_x;
			val_q     <= value;
			mode_q    <= match_mode;
			sq_fits_q <= (key_sq[63:31] == 33'd0);
			sq_low_q  <= key_sq[30:0];
		end
	end

	// Command sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			ptr_q        <= '0;
			lim_q        <= '0;
			issue_q      <= 1'b0;
			res_status_q <= STS_OK;
			res_found_q  <= '0;
			res_elem_q   <= '0;
		end else begin
			// Address walk shared by all loops; a locate hit ends it on its own.
			if (issue_q && !scan_hit) begin
				if (ptr_q == lim_q) begin
					issue_q <= 1'b0;
				end else if (state_q == ST_UP) begin
					ptr_q <= ptr_q - PW'(1);
				end else begin
					ptr_q <= ptr_q + PW'(1);
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						res_found_q <= '0;
						res_elem_q  <= '0;
						unique case (command)
							CMD_INSERT: begin
								if (pos_x > cnt_x) begin
									res_status_q <= STS_BAD_INS;
									state_q      <= ST_FINISH;
								end else if (cnt_q == CW'(CAPACITY)) begin
									res_status_q <= STS_FULL;
									state_q      <= ST_FINISH;
								end else begin
									res_status_q <= STS_OK;
									ptr_q        <= cnt_x - PW'(1);
									lim_q        <= pos_x;
									issue_q      <= (pos_x < cnt_x);
									state_q      <= ST_UP;
								end
							end
							CMD_DELETE: begin
								if (pos_x >= cnt_x) begin
									res_status_q <= STS_BAD_DEL;
									state_q      <= ST_FINISH;
								end else begin
									res_status_q <= STS_OK;
									ptr_q        <= pos_x + PW'(1);
									lim_q        <= cnt_x - PW'(1);
									issue_q      <= ((pos_x + PW'(1)) < cnt_x);
									state_q      <= ST_DN;
								end
							end
							CMD_LOCATE: begin
								if (cnt_q == '0) begin
									res_status_q <= STS_NOT_FOUND;
									state_q      <= ST_FINISH;
								end else begin
									res_status_q <= STS_OK;
									ptr_q        <= '0;
									lim_q        <= cnt_x - PW'(1);
									issue_q      <= 1'b1;
									state_q      <= ST_SCAN;
								end
							end
							CMD_NEXT: begin
								if ((pos_x + PW'(1)) < cnt_x) begin
									res_status_q <= STS_OK;
									ptr_q        <= pos_x + PW'(1);
									lim_q        <= pos_x + PW'(1);
									issue_q      <= 1'b1;
									state_q      <= ST_NBR;
								end else begin
									res_status_q <= STS_NO_NEXT;
									state_q      <= ST_FINISH;
								end
							end
							CMD_PRIOR: begin
								if (pos_x != '0 && pos_x < cnt_x) begin
									res_status_q <= STS_OK;
									ptr_q        <= pos_x - PW'(1);
									lim_q        <= pos_x - PW'(1);
									issue_q      <= 1'b1;
									state_q      <= ST_NBR;
								end else begin
									res_status_q <= STS_NO_PRIOR;
									state_q      <= ST_FINISH;
								end
							end
							default: begin
								res_status_q <= STS_OK;
								state_q      <= ST_FINISH;
							end
						endcase
					end
				end
				ST_UP: begin
					// The final cycle writes the new value; the count grows with it.
					if (!issue_q && !rd_vld_s1) begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= ST_FINISH;
					end
				end
				ST_DN: begin
					if (!issue_q && !rd_vld_s1) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= ST_FINISH;
					end
				end
				ST_SCAN: begin
					// Reads still in flight after a hit are dropped.
					if (scan_hit) begin
						res_found_q <= 4'(rd_addr_s1);
						issue_q     <= 1'b0;
						state_q     <= ST_FINISH;
					end else if (rd_vld_s1 && !issue_q) begin
						res_status_q <= STS_NOT_FOUND;
						state_q      <= ST_FINISH;
					end
				end
				ST_NBR: begin
					if (rd_vld_s1) begin
						res_elem_q <= rd_data_s1;
						state_q    <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register; it holds a transfer until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			status_q <= res_status_q;
			found_q  <= res_found_q;
			elem_q   <= res_elem_q;
			len_q    <= 5'(cnt_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_index = found_q;
	assign element     = elem_q;
	assign list_length = len_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside the finish step");

	a_read_in_loop: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> (state_q != ST_IDLE && state_q != ST_FINISH))
		else $error("memory read outside a walk");

	a_full_no_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UP && cnt_q == CW'(CAPACITY)) |-> 1'b0)
		else $error("insert walk started on a full store");
`endif

endmodule

[tb/sle_list_checker.sv]
// Transfer monitor, list predictor and result comparator for the sequential list engine.
`timescale 1ns / 100ps

module sle_list_checker
	import sle_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [2:0]         command,
	input  logic [4:0]         position,
	input  logic signed [31:0] value,
	input  logic [1:0]         match_mode,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [2:0]         status,
	input  logic [3:0]         found_index,
	input  logic signed [31:0] element,
	input  logic [4:0]         list_length,
	output int                 pending_count,
	output int                 error_count
);

	// One result as the block should return it.
	typedef struct packed {
		logic [2:0]         status;
		logic [3:0]         found_index;
		logic signed [31:0] element;
		logic [4:0]         list_length;
	} list_result_t;

	// Shadow copy of the list contents and its length.
	logic signed [31:0] list_entries [DEPTH];
	int                 list_count;

	// Results owed by the block, oldest first.
	list_result_t       pending_results [$];
	list_result_t       want_result;

	initial begin
		list_count = 0;
		pending_count = 0;
		error_count = 0;
	end

	// Locate test on full-precision values, so squares never wrap.
	function automatic bit key_hits(input logic signed [31:0] entry,
		input logic signed [31:0] key, input logic [1:0] mode);
		longint e;
		longint k;
		bit     hit;
		e = entry;
		k = key;
		hit = 1'b0;
		case (mode)
			MODE_EQUAL:    hit = (e == k);
			MODE_KEY_SQ:   hit = (e == k * k);
			MODE_ENTRY_SQ: hit = (e >= 0) && (k >= 0) && (e * e == k);
			default:       hit = 1'b0;
		endcase
		return hit;
	endfunction

	// Applies one command to the shadow list and returns the result it gives.
	function automatic list_result_t apply_list_command(input logic [2:0] cmd,
		input logic [4:0] pos, input logic signed [31:0] val, input logic [1:0] mode);
		list_result_t r;
		int           j;
		bit           hit_seen;
		r = '0;
		r.status = STS_OK;
		hit_seen = 1'b0;
		case (cmd)
			CMD_INSERT: begin
				if (pos > list_count) begin
					r.status = STS_BAD_INS;
				end else if (list_count >= DEPTH) begin
					r.status = STS_FULL;
				end else begin
					for (j = list_count; j > pos; j--)
						list_entries[j] = list_entries[j - 1];
					list_entries[pos] = val;
					list_count++;
				end
			end
			CMD_DELETE: begin
				if (pos >= list_count) begin
					r.status = STS_BAD_DEL;
				end else begin
					for (j = pos; j + 1 < list_count; j++)
						list_entries[j] = list_entries[j + 1];
					list_count--;
				end
			end
			CMD_LOCATE: begin
				r.status = STS_NOT_FOUND;
				for (j = 0; j < list_count; j++) begin
					if (!hit_seen && key_hits(list_entries[j], val, mode)) begin
						hit_seen = 1'b1;
						r.status = STS_OK;
						r.found_index = 4'(j);
					end
				end
			end
			CMD_NEXT: begin
				if (pos + 1 >= list_count)
					r.status = STS_NO_NEXT;
				else
					r.element = list_entries[pos + 1];
			end
			CMD_PRIOR: begin
				if (pos == 0 || pos >= list_count)
					r.status = STS_NO_PRIOR;
				else
					r.element = list_entries[pos - 1];
			end
			// Unused command codes leave the list alone and report ok.
			default: ;
		endcase
		r.list_length = 5'(list_count);
		return r;
	endfunction

	task automatic check_field(input string field_name, input logic signed [32:0] want,
		input logic signed [32:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field_name, want, got);
			error_count++;
		end
	endtask

	// Compare each result transfer against the oldest prediction, then record any new
	// command transfer. A result can never leave in the cycle its command arrives.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, got status %0d length %0d",
						$time, status, list_length);
					error_count++;
				end else begin
					want_result = pending_results.pop_front();
					check_field("status", want_result.status, status);
					check_field("found_index", want_result.found_index, found_index);
					check_field("element", want_result.element, element);
					check_field("list_length", want_result.list_length, list_length);
				end
			end
			if (in_valid && !in_stall)
				pending_results.push_back(apply_list_command(command, position, value,
					match_mode));
			pending_count = pending_results.size();
		end
	end

endmodule

[tb/sequential_list_engine_tb.sv]
// Top of the sequential list engine testbench: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module sequential_list_engine_tb;
	import sle_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int TOTAL_ITEMS = 650;
	localparam int HOLD_CYCLES = 300;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef enum {PH_GROW, PH_SHRINK, PH_MIXED} phase_kind_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         command;
	logic [4:0]         position;
	logic signed [31:0] value;
	logic [1:0]         match_mode;
	logic               out_valid;
	logic               out_stall;
	logic [2:0]         status;
	logic [3:0]         found_index;
	logic signed [31:0] element;
	logic [4:0]         list_length;

	int                 pending_count;
	int                 error_count;
	int                 sent_count;
	bit                 no_gaps;
	bit                 hold_request;
	bit                 hold_done;

	sequential_list_engine #(
		.CAPACITY(LIST_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.position(position),
		.value(value),
		.match_mode(match_mode),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.found_index(found_index),
		.element(element),
		.list_length(list_length)
	);

	sle_list_checker #(
		.DEPTH(LIST_DEPTH)
	) u_list_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.position(position),
		.value(value),
		.match_mode(match_mode),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.found_index(found_index),
		.element(element),
		.list_length(list_length),
		.pending_count(pending_count),
		.error_count(error_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hard stop in case the block hangs.
	initial begin
		#5_000_000;
		$display("sequential_list_engine_tb: done, errors");
		$finish;
	end

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 45)
			return 0;
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Values lean toward small numbers and their squares so that locates hit.
	function automatic logic signed [31:0] pick_value();
		int s;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, 24) - 12;
			4, 5: begin
				s = $urandom_range(0, 12);
				return s * s;
			end
			6: begin
				case ($urandom_range(0, 5))
					0:       return 32'sh8000_0000;
					1:       return 32'sh7fff_ffff;
					2:       return 46340;
					3:       return -46340;
					4:       return 46341;
					default: return 2147395600;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Positions favor the head of the list, with some past any possible length.
	function automatic logic [4:0] pick_position();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return 5'd0;
		if (r < 8)
			return 5'($urandom_range(0, LIST_DEPTH + 1));
		return 5'($urandom);
	endfunction

	function automatic logic [1:0] pick_mode();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return MODE_UNUSED;
		if (r < 8)
			return MODE_EQUAL;
		if (r < 14)
			return MODE_KEY_SQ;
		return MODE_ENTRY_SQ;
	endfunction

	// Presents one command from a falling edge and returns at the falling edge after its
	// transfer, with valid still high.
	task automatic offer_command(input logic [2:0] cmd, input logic [4:0] pos,
		input logic signed [31:0] val, input logic [1:0] mode);
		in_valid <= 1'b1;
		command <= cmd;
		position <= pos;
		value <= val;
		match_mode <= mode;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		sent_count++;
	endtask

	task automatic issue_command(input logic [2:0] cmd, input logic [4:0] pos,
		input logic signed [31:0] val, input logic [1:0] mode);
		int gap;
		offer_command(cmd, pos, val, mode);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Stop sending until every predicted result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
	endtask

	// Result side: random stalls with quiet stretches, and one long hold-off while the
	// sender keeps going so the block backs up into its input.
	initial begin
		int n;
		int r;
		out_stall = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (hold_request && !hold_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_done = 1'b1;
			end else if (r < 10) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(20, 80)) @(negedge clk);
			end else if (r < 45) begin
				out_stall <= 1'b1;
				n = (r < 42) ? $urandom_range(1, 4) : $urandom_range(15, 40);
				repeat (n) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
	end

	// Command side.
	initial begin
		phase_kind_t        kind;
		int                 phase_index;
		int                 phase_len;
		int                 ins_w;
		int                 del_w;
		int                 i;
		logic [2:0]         cmd;
		logic [1:0]         mode;

		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_INSERT;
		position = 5'd0;
		value = 32'sd0;
		match_mode = MODE_EQUAL;
		sent_count = 0;
		no_gaps = 1'b0;
		hold_request = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty list: every command that needs an entry must refuse.
		issue_command(CMD_DELETE, 5'd0, 32'sd0, MODE_EQUAL);
		issue_command(CMD_NEXT, 5'd0, 32'sd0, MODE_EQUAL);
		issue_command(CMD_PRIOR, 5'd0, 32'sd0, MODE_EQUAL);
		issue_command(CMD_LOCATE, 5'd0, 32'sd0, MODE_EQUAL);
		issue_command(CMD_INSERT, 5'd1, 32'sd5, MODE_EQUAL);

		// Build -1, min, 4, max, 0 with inserts at head, middle and tail.
		issue_command(CMD_INSERT, 5'd0, 32'sh8000_0000, MODE_EQUAL);
		issue_command(CMD_INSERT, 5'd1, 32'sh7fff_ffff, MODE_EQUAL);
		issue_command(CMD_INSERT, 5'd1, 32'sd4, MODE_EQUAL);
		issue_command(CMD_INSERT, 5'd0, -32'sd1, MODE_EQUAL);
		issue_command(CMD_INSERT, 5'd4, 32'sd0, MODE_EQUAL);

		// Locate under each test and an unused mode, including keys whose square does not fit in 31 bits.
		issue_command(CMD_LOCATE, 5'd0, 32'sh8000_0000, MODE_EQUAL);
		issue_command(CMD_LOCATE, 5'd0, -32'sd2, MODE_KEY_SQ);
		issue_command(CMD_LOCATE, 5'd0, 32'sd16, MODE_ENTRY_SQ);
		issue_command(CMD_LOCATE, 5'd0, 32'sd0, MODE_ENTRY_SQ);
		issue_command(CMD_LOCATE, 5'd0, 32'sd46341, MODE_KEY_SQ);
		issue_command(CMD_LOCATE, 5'd0, 32'sh8000_0000, MODE_KEY_SQ);
		issue_command(CMD_LOCATE, 5'd0, 32'sd4, MODE_UNUSED);

		// Neighbors at both ends and positions past the length.
		issue_command(CMD_NEXT, 5'd0, 32'sd0, MODE_EQUAL);
		issue_command(CMD_NEXT, 5'd4, 32'sd0, MODE_EQUAL);
		issue_command(CMD_PRIOR, 5'd4, 32'sd0, MODE_EQUAL);
		issue_command(CMD_PRIOR, 5'd5, 32'sd0, MODE_EQUAL);
		issue_command(CMD_NEXT, 5'd31, 32'sd0, MODE_EQUAL);
		issue_command(CMD_PRIOR, 5'd31, -32'sd1, MODE_UNUSED);

		// Deletes at tail, head and out of range, then unused command codes.
		issue_command(CMD_DELETE, 5'd31, 32'sd0, MODE_EQUAL);
		issue_command(CMD_DELETE, 5'd4, 32'sd0, MODE_EQUAL);
		issue_command(CMD_DELETE, 5'd0, 32'sd0, MODE_EQUAL);
		issue_command(3'(CMD_PRIOR) + 3'd1, 5'd31, -32'sd1, MODE_UNUSED);
		issue_command(3'(CMD_PRIOR) + 3'd3, 5'd0, 32'sd0, MODE_EQUAL);
		drain_results();

		// Random phases: a growing phase first, then a shrinking one, then phases of random kind.
		phase_index = 0;
		while (sent_count < TOTAL_ITEMS) begin
			if (phase_index == 0)
				kind = PH_GROW;
			else if (phase_index == 1)
				kind = PH_SHRINK;
			else
				kind = phase_kind_t'($urandom_range(0, 2));
			case (kind)
				PH_GROW: begin
					ins_w = 60;
					del_w = 8;
				end
				PH_SHRINK: begin
					ins_w = 12;
					del_w = 50;
				end
				default: begin
					ins_w = 30;
					del_w = 25;
				end
			endcase
			phase_len = $urandom_range(40, 90);
			no_gaps = ($urandom_range(0, 3) == 0);
			if (phase_index == 0)
				hold_request = 1'b1;

			for (i = 0; i < phase_len && sent_count < TOTAL_ITEMS; i++) begin
				if ($urandom_range(0, 99) < ins_w) begin
					cmd = CMD_INSERT;
				end else if ($urandom_range(0, 99) < del_w) begin
					cmd = CMD_DELETE;
				end else begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3, 4: cmd = CMD_LOCATE;
						5, 6:          cmd = CMD_NEXT;
						7, 8:          cmd = CMD_PRIOR;
						default:       cmd = 3'(CMD_PRIOR) + 3'($urandom_range(1, 3));
					endcase
				end
				mode = (cmd == CMD_LOCATE) ? pick_mode() : 2'($urandom);
				issue_command(cmd, pick_position(), pick_value(), mode);
			end

			if ($urandom_range(0, 1) == 0)
				drain_results();
			phase_index++;
		end

		// Let the last results out, then allow a worst-case command time for strays.
		drain_results();
		repeat (4 * LIST_DEPTH) @(negedge clk);
		if (error_count == 0)
			$display("sequential_list_engine_tb: done, clean");
		else
			$display("sequential_list_engine_tb: done, errors");
		$finish;
	end

endmodule

[sequential_list_engine.f]
rtl/core/sle_pkg.sv
rtl/core/sequential_list_engine.sv
tb/sle_list_checker.sv
tb/sequential_list_engine_tb.sv
